### design/mme_pkg.sv
// Shared types and constants for the Montgomery modular exponentiation block.
package mme_pkg;

    localparam int DATA_W     = 32;
    localparam int ERR_W      = 2;
    localparam int IN_TDATA_W = 2 * DATA_W;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_EVEN = 2'd1,
        ERR_BASE = 2'd2
    } err_code_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RSQ,
        ST_MR,
        ST_MP,
        ST_SCAN,
        ST_MUL,
        ST_SQR,
        ST_FIN,
        ST_OUT
    } mme_state_t;

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_RUN,
        MM_FIX
    } mm_state_t;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_WIDTH,
        RS_DOUBLE
    } rs_state_t;

endpackage

### design/mme_rsq.sv
// Bit count of the modulus and R^2 mod modulus by serial doubling.
module mme_rsq #(
    parameter int W = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [W-1:0]             m,
    output logic                     done,
    output logic [W-1:0]             r2,
    output logic [$clog2(W+1)-1:0]   k
);

    localparam int KW = $clog2(W + 1);
    localparam int CW = $clog2(2 * W + 1);

    mme_pkg::rs_state_t state_reg, state_next;
    logic [W-1:0]  mw_reg, mw_next;
    logic [KW-1:0] k_reg, k_next;
    logic [W-1:0]  r_reg, r_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [W:0]    dbl;
    logic          last;

    assign dbl  = {r_reg, 1'b0};
    assign last = (cnt_reg == (CW'({k_reg, 1'b0}) - CW'(1)));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mme_pkg::RS_IDLE:
            begin
                if (start)
                    state_next = mme_pkg::RS_WIDTH;
            end
            mme_pkg::RS_WIDTH:
            begin
                if (mw_reg == '0)
                    state_next = mme_pkg::RS_DOUBLE;
            end
            mme_pkg::RS_DOUBLE:
            begin
                if (last)
                    state_next = mme_pkg::RS_IDLE;
            end
            default:
                state_next = mme_pkg::RS_IDLE;
        endcase
    end

    always_comb
    begin
        mw_next   = mw_reg;
        k_next    = k_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        case (state_reg)
            mme_pkg::RS_IDLE:
            begin
                if (start)
                begin
                    mw_next = m;
                    k_next  = '0;
                end
            end
            mme_pkg::RS_WIDTH:
            begin
                if (mw_reg == '0)
                begin
                    // modulus of one gives R^2 mod 1 = 0
                    r_next   = (m == W'(1)) ? '0 : W'(1);
                    cnt_next = '0;
                end
                else
                begin
                    mw_next = mw_reg >> 1;
                    k_next  = k_reg + KW'(1);
                end
            end
            mme_pkg::RS_DOUBLE:
            begin
                if (dbl >= {1'b0, m})
                    r_next = W'(dbl - {1'b0, m});
                else
                    r_next = dbl[W-1:0];
                cnt_next  = cnt_reg + CW'(1);
                done_next = last;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mme_pkg::RS_IDLE;
            k_reg     <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mw_reg <= mw_next;
        r_reg  <= r_next;
    end

    assign done = done_reg;
    assign r2   = r_reg;
    assign k    = k_reg;

    a_rsq_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (r_reg < m))
        else $error("R^2 residue not reduced below modulus");

endmodule

### design/mme_montmul.sv
// Radix-2 bit-serial Montgomery product, one multiplier bit per cycle.
module mme_montmul #(
    parameter int W = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [W-1:0]             x,
    input  logic [W-1:0]             y,
    input  logic [W-1:0]             m,
    input  logic [$clog2(W+1)-1:0]   k,
    output logic                     done,
    output logic [W-1:0]             result
);

    localparam int KW = $clog2(W + 1);

    mme_pkg::mm_state_t state_reg, state_next;
    logic [W:0]    t_reg, t_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic          xb;
    logic          nb;
    logic [W-1:0]  ysel;
    logic [W-1:0]  msel;
    logic [W+1:0]  sum;
    logic          last;

    assign xb   = x_reg[0];
    assign nb   = t_reg[0] ^ (xb & y_reg[0]);
    assign ysel = xb ? y_reg : '0;
    assign msel = nb ? m : '0;
    assign sum  = {1'b0, t_reg} + {2'b00, ysel} + {2'b00, msel};
    assign last = (cnt_reg == (k - KW'(1)));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mme_pkg::MM_IDLE:
            begin
                if (start)
                    state_next = mme_pkg::MM_RUN;
            end
            mme_pkg::MM_RUN:
            begin
                if (last)
                    state_next = mme_pkg::MM_FIX;
            end
            mme_pkg::MM_FIX:
                state_next = mme_pkg::MM_IDLE;
            default:
                state_next = mme_pkg::MM_IDLE;
        endcase
    end

    always_comb
    begin
        t_next    = t_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        case (state_reg)
            mme_pkg::MM_IDLE:
            begin
                if (start)
                begin
                    t_next   = '0;
                    x_next   = x;
                    y_next   = y;
                    cnt_next = '0;
                end
            end
            mme_pkg::MM_RUN:
            begin
                // T = (T + xb*Y + n*M) / 2
                t_next   = sum[W+1:1];
                x_next   = x_reg >> 1;
                cnt_next = cnt_reg + KW'(1);
            end
            mme_pkg::MM_FIX:
            begin
                if (t_reg >= {1'b0, m})
                    t_next = t_reg - {1'b0, m};
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mme_pkg::MM_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            t_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            t_reg     <= t_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign done   = done_reg;
    assign result = t_reg[W-1:0];

    a_mm_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (t_reg < {1'b0, m}))
        else $error("Montgomery product not reduced below modulus");

endmodule

### design/montgomery_modular_exponentiation.sv
// Top level: Montgomery modular exponentiation, base^exponent mod modulus.
//
// channel  | valid / ready                | payload
// s_axis   | s_axis_tvalid, s_axis_tready | tdata: base [31:0], exponent [63:32]
// m_axis   | m_axis_tvalid, m_axis_tready | tdata: power_result; tuser: error_code
// cfg      | cfg_we                       | cfg_wdata: modulus
//
// k is the bit count of the modulus; the bit-serial product unit steps through k
// multiplier bits per product. An item costs an R^2 setup by serial doubling, then
// (3 + ones + bits_of_exponent) products plus one scan step per exponent bit.
// Errors skip the products and go straight to the output state. Reset clears
// control only; modulus resets to 1.
// Input is taken only when idle; a finished word waits in the output
// register while the next item is accepted.
module montgomery_modular_exponentiation #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mme_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // base, exponent
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mme_pkg::DATA_W-1:0]        m_axis_tdata,  // power_result
    output logic [mme_pkg::ERR_W-1:0]         m_axis_tuser,  // error_code
    input  logic                              cfg_we,
    input  logic [mme_pkg::DATA_W-1:0]        cfg_wdata
);

    localparam int W  = OPERAND_WIDTH;
    localparam int KW = $clog2(W + 1);
    localparam int DW = mme_pkg::DATA_W;

    mme_pkg::mme_state_t state_reg, state_next;
    mme_pkg::err_code_t  err_reg, out_err_reg;

    logic [W-1:0]    modulus_reg;
    logic [W-1:0]    base_reg;
    logic [W-1:0]    exp_reg;
    logic [W-1:0]    result_reg;
    logic [W-1:0]    power_reg;
    logic            out_valid_reg;
    logic [DW-1:0]   out_data_reg;

    logic [W+DW-1:0] cfg_ext, base_ext, exp_ext, res_ext;
    logic [W-1:0]    base_in, exp_in;
    logic            accept;
    logic            bad_even, bad_base;

    logic            rsq_start, rsq_done;
    logic [W-1:0]    r2;
    logic [KW-1:0]   k;
    logic            mul_start, mul_done;
    logic [W-1:0]    mul_x, mul_y, prod;
    logic            out_load;

    assign cfg_ext  = {{W{1'b0}}, cfg_wdata};
    assign base_ext = {{W{1'b0}}, s_axis_tdata[DW-1:0]};
    assign exp_ext  = {{W{1'b0}}, s_axis_tdata[2*DW-1:DW]};
    assign res_ext  = {{DW{1'b0}}, result_reg};
    assign base_in  = base_ext[W-1:0];
    assign exp_in   = exp_ext[W-1:0];

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign bad_even = ~modulus_reg[0];
    assign bad_base = (base_in >= modulus_reg);

    mme_rsq #(.W(W)) u_rsq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rsq_start),
        .m     (modulus_reg),
        .done  (rsq_done),
        .r2    (r2),
        .k     (k)
    );

    mme_montmul #(.W(W)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .x      (mul_x),
        .y      (mul_y),
        .m      (modulus_reg),
        .k      (k),
        .done   (mul_done),
        .result (prod)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mme_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = (bad_even || bad_base) ? mme_pkg::ST_OUT : mme_pkg::ST_RSQ;
            end
            mme_pkg::ST_RSQ:
            begin
                if (rsq_done)
                    state_next = mme_pkg::ST_MR;
            end
            mme_pkg::ST_MR:
            begin
                if (mul_done)
                    state_next = mme_pkg::ST_MP;
            end
            mme_pkg::ST_MP:
            begin
                if (mul_done)
                    state_next = mme_pkg::ST_SCAN;
            end
            mme_pkg::ST_SCAN:
            begin
                if (exp_reg == '0)
                    state_next = mme_pkg::ST_FIN;
                else if (exp_reg[0])
                    state_next = mme_pkg::ST_MUL;
                else
                    state_next = mme_pkg::ST_SQR;
            end
            mme_pkg::ST_MUL:
            begin
                if (mul_done)
                    state_next = mme_pkg::ST_SQR;
            end
            mme_pkg::ST_SQR:
            begin
                if (mul_done)
                    state_next = mme_pkg::ST_SCAN;
            end
            mme_pkg::ST_FIN:
            begin
                if (mul_done)
                    state_next = mme_pkg::ST_OUT;
            end
            mme_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = mme_pkg::ST_IDLE;
            end
            default:
                state_next = mme_pkg::ST_IDLE;
        endcase
    end

    // control outputs; product operands are latched by the unit at start
    always_comb
    begin
        s_axis_tready = 1'b0;
        rsq_start     = 1'b0;
        mul_start     = 1'b0;
        mul_x         = W'(1);
        mul_y         = r2;
        out_load      = 1'b0;
        case (state_reg)
            mme_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                rsq_start     = accept && !bad_even && !bad_base;
            end
            mme_pkg::ST_RSQ:
            begin
                mul_start = rsq_done;
            end
            mme_pkg::ST_MR:
            begin
                mul_start = mul_done;
                mul_x     = base_reg;
            end
            mme_pkg::ST_SCAN:
            begin
                mul_start = 1'b1;
                if (exp_reg == '0)
                begin
                    mul_x = W'(1);
                    mul_y = result_reg;
                end
                else if (exp_reg[0])
                begin
                    mul_x = result_reg;
                    mul_y = power_reg;
                end
                else
                begin
                    mul_x = power_reg;
                    mul_y = power_reg;
                end
            end
            mme_pkg::ST_MUL:
            begin
                // squaring uses the power, which this product does not touch
                mul_start = mul_done;
                mul_x     = power_reg;
                mul_y     = power_reg;
            end
            mme_pkg::ST_OUT:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mme_pkg::ST_IDLE;
            modulus_reg   <= W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                modulus_reg <= cfg_ext[W-1:0];
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_reg   <= base_in;
            exp_reg    <= exp_in;
            result_reg <= '0;
            if (bad_even)
                err_reg <= mme_pkg::ERR_EVEN;
            else if (bad_base)
                err_reg <= mme_pkg::ERR_BASE;
            else
                err_reg <= mme_pkg::ERR_NONE;
        end
        if (mul_done)
        begin
            case (state_reg)
                mme_pkg::ST_MR, mme_pkg::ST_FIN:
                    result_reg <= prod;
                mme_pkg::ST_MP:
                    power_reg <= prod;
                mme_pkg::ST_MUL:
                begin
                    result_reg <= prod;
                    exp_reg    <= exp_reg >> 1;
                end
                mme_pkg::ST_SQR:
                    power_reg <= prod;
                default:
                    power_reg <= power_reg;
            endcase
        end
        // an even exponent bit skips the multiply and shifts here
        if (state_reg == mme_pkg::ST_SCAN && exp_reg != '0 && !exp_reg[0])
            exp_reg <= exp_reg >> 1;
        if (out_load)
        begin
            out_data_reg <= res_ext[DW-1:0];
            out_err_reg  <= err_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_err_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg != mme_pkg::ERR_NONE) |-> (out_data_reg == '0))
        else $error("error word carries a nonzero result");

    a_mul_owner: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == mme_pkg::ST_MR || state_reg == mme_pkg::ST_MP ||
                      state_reg == mme_pkg::ST_MUL || state_reg == mme_pkg::ST_SQR ||
                      state_reg == mme_pkg::ST_FIN))
        else $error("product finished outside a product state");

    a_rsq_owner: assert property (@(posedge clk) disable iff (!rst_n)
        rsq_done |-> (state_reg == mme_pkg::ST_RSQ))
        else $error("R^2 setup finished outside its state");

endmodule
